>>> rtl/hsl_pkg.sv
// shared types, constants and helper functions for the hsl to rgb converter
// no dependencies; compiled first
package hsl_pkg;

   localparam int HUE_W   = 9;
   localparam int FIX_W   = 16;
   localparam int CHAN_W  = 8;
   localparam int WGT_W   = 6;
   localparam int SUM_W   = HUE_W + 1;

   localparam int HUE_WRAP   = 360;
   localparam int RED_OFFS   = 120;
   localparam int BLUE_OFFS  = 240;
   localparam int SEG_RISE   = 60;
   localparam int SEG_FLAT   = 180;
   localparam int SEG_FALL   = 240;
   localparam int SEG_FULL   = 60;
   localparam int GREY_SCALE = 255;
   localparam int CHAN_MAX   = 255;
   // 255 / 60 reduces to 17 / 4
   localparam int SCALE_MUL  = 17;
   localparam int SCALE_SHR  = 2;

   typedef logic [HUE_W-1:0]  hue_type;
   typedef logic [WGT_W-1:0]  wgt_type;
   typedef logic [CHAN_W-1:0] chan_type;

   // load enables for a block that owns two pipeline stages
   typedef struct packed {
      logic first_en;
      logic second_en;
   } hsl_pair_en_type;

   // wrap a hue sum back into 0..359 (one subtract is enough)
   function automatic hue_type hue_wrap(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] red;
      red = sum - SUM_W'(HUE_WRAP);
      if (sum >= SUM_W'(HUE_WRAP)) begin
         return red[HUE_W-1:0];
      end
      return sum[HUE_W-1:0];
   endfunction

   // piecewise channel weight in whole degrees, 0..60
   function automatic wgt_type seg_weight(input hue_type p);
      hue_type fall;
      fall = HUE_W'(SEG_FALL) - p;
      if (p < HUE_W'(SEG_RISE)) begin
         return p[WGT_W-1:0];
      end else if (p < HUE_W'(SEG_FLAT)) begin
         return WGT_W'(SEG_FULL);
      end else if (p < HUE_W'(SEG_FALL)) begin
         return fall[WGT_W-1:0];
      end
      return '0;
   endfunction

endpackage

>>> rtl/hsl_if.sv
// request and response channel interfaces for the hsl to rgb converter
// depends on hsl_pkg
interface hsl_req_if import hsl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue_degrees;
   logic [FIX_W-1:0]  saturation;
   logic [FIX_W-1:0]  lightness;

   modport source (output valid, hue_degrees, saturation, lightness, input ready);
   modport sink   (input valid, hue_degrees, saturation, lightness, output ready);
endinterface

interface hsl_rsp_if import hsl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsl_prep.sv
// stages one and two: input clamp, hue wrap, l*s product and channel weights
// depends on hsl_pkg
module hsl_prep import hsl_pkg::*; #(
   parameter int FRAC_BITS = 15,
   parameter int VW        = 16
) (
   input  logic                 clock,
   input  hsl_pair_en_type      en,
   input  logic [HUE_W-1:0]     hue_degrees,
   input  logic [FIX_W-1:0]     saturation,
   input  logic [FIX_W-1:0]     lightness,
   output logic [VW-1:0]        light_ff,
   output logic [VW-1:0]        sat_ff,
   output logic [2*VW-1:0]      prod_ff,
   output logic                 grey_ff,
   output wgt_type              wgt_r_ff,
   output wgt_type              wgt_g_ff,
   output wgt_type              wgt_b_ff
);

   localparam int PW = 2 * VW;
   localparam logic [31:0] ONE_V = 32'(1) << FRAC_BITS;

   logic [VW-1:0] s1_sat_in, s1_sat_ff;
   logic [VW-1:0] s1_light_in, s1_light_ff;
   hue_type       s1_hue_in, s1_hue_ff;
   logic          s1_grey_in, s1_grey_ff;
   logic [PW-1:0] prod_in;
   hue_type       pos_r, pos_b;

   // stage one: saturate to one, fold hue 360..511 down once
   always_comb begin
      s1_sat_in   = (32'(saturation) > ONE_V) ? VW'(ONE_V) : VW'(saturation);
      s1_light_in = (32'(lightness)  > ONE_V) ? VW'(ONE_V) : VW'(lightness);
      s1_grey_in  = (saturation == '0);
      s1_hue_in   = hue_wrap(SUM_W'(hue_degrees));
   end

   always_ff @(posedge clock) begin
      if (en.first_en) begin
         s1_sat_ff   <= s1_sat_in;
         s1_light_ff <= s1_light_in;
         s1_grey_ff  <= s1_grey_in;
         s1_hue_ff   <= s1_hue_in;
      end
   end

   // stage two: product and per-channel hue positions
   always_comb begin
      prod_in = PW'(s1_light_ff) * PW'(s1_sat_ff);
      pos_r   = hue_wrap(SUM_W'(s1_hue_ff) + SUM_W'(RED_OFFS));
      pos_b   = hue_wrap(SUM_W'(s1_hue_ff) + SUM_W'(BLUE_OFFS));
   end

   always_ff @(posedge clock) begin
      if (en.second_en) begin
         light_ff <= s1_light_ff;
         sat_ff   <= s1_sat_ff;
         prod_ff  <= prod_in;
         grey_ff  <= s1_grey_ff;
         wgt_r_ff <= seg_weight(pos_r);
         wgt_g_ff <= seg_weight(s1_hue_ff);
         wgt_b_ff <= seg_weight(pos_b);
      end
   end

endmodule

>>> rtl/hsl_temp.sv
// stage three: two-temp values t2 and t1-t2, plus the grey level
// depends on hsl_pkg
module hsl_temp import hsl_pkg::*; #(
   parameter int FRAC_BITS = 15,
   parameter int VW        = 16,
   parameter int SW        = 19
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [VW-1:0]        light,
   input  logic [VW-1:0]        sat,
   input  logic [2*VW-1:0]      prod,
   output logic signed [SW-1:0] t2_ff,
   output logic signed [SW-1:0] diff_ff,
   output chan_type             grey_val_ff
);

   localparam int GW = VW + CHAN_W;
   // one half can lie above the 16-bit value field for wide fractions
   localparam logic [31:0] HALF_V = 32'(1) << (FRAC_BITS - 1);

   logic [2*VW-1:0]      ls_wide;
   logic signed [SW-1:0] ls_x, light_x, sat_x, t1, t2_in, diff_in;
   logic [GW-1:0]        grey_prod, grey_shr;

   always_comb begin
      ls_wide = prod >> FRAC_BITS;
      ls_x    = $signed(SW'(ls_wide));
      light_x = $signed(SW'(light));
      sat_x   = $signed(SW'(sat));
      // l*(1+s) folds to l + l*s, both truncated the same way
      if (32'(light) < HALF_V) begin
         t1 = light_x + ls_x;
      end else begin
         t1 = light_x + sat_x - ls_x;
      end
      t2_in     = (light_x <<< 1) - t1;
      diff_in   = t1 - t2_in;
      grey_prod = GW'(light) * GW'(GREY_SCALE);
      grey_shr  = grey_prod >> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_ff       <= t2_in;
         diff_ff     <= diff_in;
         grey_val_ff <= grey_shr[CHAN_W-1:0];
      end
   end

endmodule

>>> rtl/hsl_chan.sv
// stages four and five for one colour channel: weighted sum, scale and clamp
// depends on hsl_pkg
module hsl_chan import hsl_pkg::*; #(
   parameter int FRAC_BITS = 15,
   parameter int SW        = 19,
   parameter int NW        = 25
) (
   input  logic                 clock,
   input  hsl_pair_en_type      en,
   input  logic signed [SW-1:0] t2,
   input  logic signed [SW-1:0] diff,
   input  wgt_type              wgt,
   input  logic                 grey,
   input  chan_type             grey_val,
   output chan_type             chan_ff
);

   localparam int XW = NW + 5;
   localparam logic signed [NW-1:0] FULL_S  = NW'(SEG_FULL);
   localparam logic        [XW-1:0] LIMIT_U = XW'(CHAN_MAX);

   logic signed [NW-1:0] t2_x, diff_x, wgt_x, num_in, num_ff;
   logic                 grey_ff;
   chan_type             grey_val_ff, chan_in;
   logic signed [XW-1:0] num_xw, scaled;
   logic        [XW-1:0] quot;

   // stage four: t2*60 + (t1-t2)*w
   always_comb begin
      t2_x   = NW'(t2);
      diff_x = NW'(diff);
      wgt_x  = $signed(NW'(wgt));
      num_in = t2_x * FULL_S + diff_x * wgt_x;
   end

   always_ff @(posedge clock) begin
      if (en.first_en) begin
         num_ff      <= num_in;
         grey_ff     <= grey;
         grey_val_ff <= grey_val;
      end
   end

   // stage five: num*255/(60*one) as num*17 >> (frac+2), then clamp; grey takes the grey level
   always_comb begin
      num_xw = XW'(num_ff);
      scaled = (num_xw <<< 4) + num_xw;
      quot   = $unsigned(scaled) >> (FRAC_BITS + SCALE_SHR);
      priority if (grey_ff) begin
         chan_in = grey_val_ff;
      end else if (num_ff < 0) begin
         chan_in = '0;
      end else if (quot > LIMIT_U) begin
         chan_in = CHAN_W'(CHAN_MAX);
      end else begin
         chan_in = quot[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.second_en) begin
         chan_ff <= chan_in;
      end
   end

endmodule

>>> rtl/hsl_to_rgb_converter_unit.sv
// hsl to rgb converter, five-stage pipeline
// throughput: one request per cycle while rsp_chan.ready holds; every stage has its own valid bit and
// stalls only when it holds data and the stage after it cannot load
// reset: synchronous active-high reset clears the valid bits only
module hsl_to_rgb_converter_unit import hsl_pkg::*; #(
   parameter int FRAC_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   hsl_req_if.sink     req_chan,
   hsl_rsp_if.source   rsp_chan
);

   // clamped values never exceed one or the 16-bit field
   localparam int VW     = (FRAC_BITS < FIX_W) ? FRAC_BITS + 1 : FIX_W;
   // t2 and t1-t2 can swing to about +/- 2^(VW+1)
   localparam int SW     = VW + 3;
   // weighted sum bounded by 2^(VW+8)
   localparam int NW     = VW + 9;
   localparam int STAGES = 5;

   logic [STAGES-1:0] valid_ff, valid_in, load;

   // stage 1,2: prep   stage 3: temp   stage 4,5: channels
   hsl_pair_en_type   prep_en, chan_en;

   logic [VW-1:0]        light2, sat2;
   logic [2*VW-1:0]      prod2;
   logic                 grey2, grey3_ff;
   wgt_type              wgt_r2, wgt_g2, wgt_b2;
   wgt_type              wgt_r3_ff, wgt_g3_ff, wgt_b3_ff;
   logic signed [SW-1:0] t2_3, diff_3;
   chan_type             grey_val3;

   // a stage loads when it is empty or its successor loads too; the last
   // stage is the response register, so a pending response still lets the
   // upstream bubbles close up
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_chan.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? req_chan.valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
      prep_en.first_en  = load[0];
      prep_en.second_en = load[1];
      chan_en.first_en  = load[3];
      chan_en.second_en = load[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = load[0];
   assign rsp_chan.valid = valid_ff[STAGES-1];

   hsl_prep #(
      .FRAC_BITS (FRAC_BITS),
      .VW        (VW)
   ) u_prep (
      .clock       (clock),
      .en          (prep_en),
      .hue_degrees (req_chan.hue_degrees),
      .saturation  (req_chan.saturation),
      .lightness   (req_chan.lightness),
      .light_ff    (light2),
      .sat_ff      (sat2),
      .prod_ff     (prod2),
      .grey_ff     (grey2),
      .wgt_r_ff    (wgt_r2),
      .wgt_g_ff    (wgt_g2),
      .wgt_b_ff    (wgt_b2)
   );

   hsl_temp #(
      .FRAC_BITS (FRAC_BITS),
      .VW        (VW),
      .SW        (SW)
   ) u_temp (
      .clock       (clock),
      .en          (load[2]),
      .light       (light2),
      .sat         (sat2),
      .prod        (prod2),
      .t2_ff       (t2_3),
      .diff_ff     (diff_3),
      .grey_val_ff (grey_val3)
   );

   // side-band for stage three: weights and grey flag ride alongside
   always_ff @(posedge clock) begin
      if (load[2]) begin
         grey3_ff  <= grey2;
         wgt_r3_ff <= wgt_r2;
         wgt_g3_ff <= wgt_g2;
         wgt_b3_ff <= wgt_b2;
      end
   end

   // one channel unit each; red sits at hue+120, blue at hue+240
   hsl_chan #(
      .FRAC_BITS (FRAC_BITS),
      .SW        (SW),
      .NW        (NW)
   ) u_chan_r (
      .clock    (clock),
      .en       (chan_en),
      .t2       (t2_3),
      .diff     (diff_3),
      .wgt      (wgt_r3_ff),
      .grey     (grey3_ff),
      .grey_val (grey_val3),
      .chan_ff  (rsp_chan.red)
   );

   hsl_chan #(
      .FRAC_BITS (FRAC_BITS),
      .SW        (SW),
      .NW        (NW)
   ) u_chan_g (
      .clock    (clock),
      .en       (chan_en),
      .t2       (t2_3),
      .diff     (diff_3),
      .wgt      (wgt_g3_ff),
      .grey     (grey3_ff),
      .grey_val (grey_val3),
      .chan_ff  (rsp_chan.green)
   );

   hsl_chan #(
      .FRAC_BITS (FRAC_BITS),
      .SW        (SW),
      .NW        (NW)
   ) u_chan_b (
      .clock    (clock),
      .en       (chan_en),
      .t2       (t2_3),
      .diff     (diff_3),
      .wgt      (wgt_b3_ff),
      .grey     (grey3_ff),
      .grey_val (grey_val3),
      .chan_ff  (rsp_chan.blue)
   );

endmodule
